>>> hdl/householder_qr_decomposition_macros.svh
// assertion macros for the householder qr block
`ifndef HOUSEHOLDER_QR_DECOMPOSITION_MACROS_SVH
`define HOUSEHOLDER_QR_DECOMPOSITION_MACROS_SVH
`ifndef SYNTH
`define HHQR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HHQR_ASSERT_NEXT(name, trig, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) trig |=> prop) else $error(msg);
`else
`define HHQR_ASSERT(name, prop, msg)
`define HHQR_ASSERT_NEXT(name, trig, prop, msg)
`endif
`endif

>>> hdl/hhqr_pkg.sv
// shared constants, saturation and magnitude helpers for the householder qr block
package hhqr_pkg;
   localparam int DEF_MAX_ROWS  = 4;
   localparam int DEF_MAX_COLS  = 4;
   localparam int DEF_FRAC_BITS = 16;
   localparam int VAL_W         = 32;
   localparam int IDX_W         = 2;
   localparam int CFG_W         = 3;
   localparam int CSR_IDX_W     = 2;
   localparam int SQRT_STEPS    = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;
   localparam logic MATRIX_Q = 1'b0;
   localparam logic MATRIX_R = 1'b1;
   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

   function automatic logic [VAL_W-1:0] sat_mag(input logic [63:0] mag, input logic neg);
      logic [63:0] lim;
      begin
         lim = 64'h0000_0000_8000_0000;
         if (neg) begin
            if (mag > lim) sat_mag = VAL_MIN;
            else sat_mag = VAL_W'(64'd0 - mag);
         end else begin
            if (mag > 64'(VAL_MAX)) sat_mag = VAL_MAX;
            else sat_mag = mag[VAL_W-1:0];
         end
      end
   endfunction

   function automatic logic [VAL_W-1:0] sat_wide(input logic signed [63:0] v);
      begin
         if (v > 64'sh0000_0000_7fff_ffff) sat_wide = VAL_MAX;
         else if (v < -64'sh0000_0000_8000_0000) sat_wide = VAL_MIN;
         else sat_wide = v[VAL_W-1:0];
      end
   endfunction

   function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
      begin
         mag32 = v[VAL_W-1] ? (32'd0 - v) : v;
      end
   endfunction
endpackage

>>> hdl/householder_qr_decomposition.sv
// householder qr decomposition of a small fixed-point matrix with one shared multiplier
// loading: one request per cycle while idle; a request with tlast runs the decomposition
// per column j (len = m-j): norm by squaring and a square root, divider steps for tau and w,
// then a dot product and update for each of the (n-j) r columns and m q rows, all on one multiplier
// output: m*m + m*n responses, one per cycle when not stalled; not ready until the last is taken
// reset: synchronous, restores rows_in_use = cols_in_use = 4 and the zero-column flag
`include "householder_qr_decomposition_macros.svh"
module householder_qr_decomposition #(
   parameter int MAX_ROWS  = hhqr_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = hhqr_pkg::DEF_MAX_COLS,
   parameter int FRAC_BITS = hhqr_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // row_index, col_index, elem_value, zero pad
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_row, out_col, out_value, zero pad
   output logic [1:0]  rsp_tuser,   // which_matrix, zero_column
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [hhqr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hhqr_pkg::CFG_W-1:0]     csr_data
);
   localparam int CW   = $clog2(MAX_ROWS + 1);
   localparam int WIW  = $clog2(MAX_ROWS);
   localparam int RAW  = $clog2(MAX_ROWS * MAX_COLS);
   localparam int QAW  = $clog2(MAX_ROWS * MAX_ROWS);
   localparam int NUMW = hhqr_pkg::VAL_W + FRAC_BITS;
   localparam int DCW  = $clog2(NUMW);
   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_NSQ   = 4'd1;
   localparam logic [3:0] ST_NACC  = 4'd2;
   localparam logic [3:0] ST_SQRT  = 4'd3;
   localparam logic [3:0] ST_PIVOT = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_WNEXT = 4'd6;
   localparam logic [3:0] ST_DOTM  = 4'd7;
   localparam logic [3:0] ST_DOTA  = 4'd8;
   localparam logic [3:0] ST_DM    = 4'd9;
   localparam logic [3:0] ST_DG    = 4'd10;
   localparam logic [3:0] ST_UPM   = 4'd11;
   localparam logic [3:0] ST_UPW   = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;
   localparam logic [3:0] ST_DRAIN = 4'd14;

   logic [31:0] r_ff [MAX_ROWS*MAX_COLS];
   logic [31:0] q_ff [MAX_ROWS*MAX_ROWS];
   logic [31:0] w_ff [MAX_ROWS];

   logic [3:0]  state_ff, state_in;
   logic [2:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [CW-1:0] m_ff, m_in, n_ff, n_in, j_ff, j_in, k_ff, k_in, c_ff, c_in;
   logic        ph_ff, ph_in, deg_ff, deg_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in, sx_ff, sx_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [4:0]  scnt_ff, scnt_in;
   logic [31:0] u1_ff, u1_in, tau_ff, tau_in, d_ff, d_in;
   logic signed [39:0] s_ff, s_in;
   logic [NUMW-1:0] dnum_ff, dnum_in;
   logic [31:0] drem_ff, drem_in, dden_ff, dden_in;
   logic        dneg_ff, dneg_in, dw_ff, dw_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [CW-1:0] or_ff, or_in, oc_ff, oc_in;
   logic        oph_ff, oph_in;
   logic        vld_ff, vld_in, last_ff, last_in, wm_ff, wm_in;
   logic [1:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic [31:0] oval_ff, oval_in;

   logic        req_acc, r_we, q_we, q_init, w_we;
   logic [RAW-1:0] r_waddr, r_raddr;
   logic [QAW-1:0] q_waddr, q_raddr;
   logic [WIW-1:0] w_waddr;
   logic [31:0] r_wdata, q_wdata, w_wdata, r_rd, q_rd, e_val, w_rd;
   logic [CW-1:0] jk, lm1, rr, rc, qr, qc;
   logic [2:0]  m3, n3;
   logic [31:0] mul_a, mul_b, mulq, norm, bneg, dres, rjj, u1c;
   logic [63:0] pmag, st;
   logic [64:0] asum;
   logic [32:0] drt;
   logic        dge;
   logic [NUMW-1:0] dnum_n;
   logic signed [32:0] diff;
   logic        o_fire, o_last;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {deg_ff, wm_ff};
   assign rsp_tdata  = {4'd0, oval_ff, ocol_ff, orow_ff};

   assign jk  = j_ff + k_ff;
   assign lm1 = m_ff - j_ff - CW'(1);
   assign rr  = (state_ff == ST_OUT) ? or_ff : jk;
   assign rc  = (state_ff == ST_OUT) ? oc_ff :
                ((state_ff == ST_NSQ || state_ff == ST_WNEXT || state_ff == ST_PIVOT) ?
                 j_ff : c_ff);
   assign qr  = (state_ff == ST_OUT) ? or_ff : c_ff;
   assign qc  = (state_ff == ST_OUT) ? oc_ff : jk;
   assign r_raddr = RAW'(int'(rr) * MAX_COLS + int'(rc));
   assign q_raddr = QAW'(int'(qr) * MAX_ROWS + int'(qc));
   assign r_rd  = r_ff[r_raddr];
   assign q_rd  = q_ff[q_raddr];
   assign w_rd  = w_ff[k_ff[WIW-1:0]];
   assign e_val = ph_ff ? q_rd : r_rd;

   assign pmag = prod_ff[63] ? (64'd0 - 64'(prod_ff)) : 64'(prod_ff);
   assign mulq = hhqr_pkg::sat_mag(pmag >> FRAC_BITS, prod_ff[63]);
   assign asum = {1'b0, acc_ff} + {1'b0, 64'(prod_ff)};
   assign st   = sres_ff + sbit_ff;
   assign norm = (sres_ff > 64'(hhqr_pkg::VAL_MAX)) ? hhqr_pkg::VAL_MAX : sres_ff[31:0];
   assign rjj  = r_rd;
   assign u1c  = rjj[31] ? hhqr_pkg::sat_wide(64'(signed'(rjj)) - 64'(signed'(norm)))
                         : hhqr_pkg::sat_wide(64'(signed'(rjj)) + 64'(signed'(norm)));
   assign bneg = rjj[31] ? (32'd0 - norm) : norm;
   assign drt    = {drem_ff, dnum_ff[NUMW-1]};
   assign dge    = drt >= {1'b0, dden_ff};
   assign dnum_n = {dnum_ff[NUMW-2:0], dge};
   assign dres   = (dden_ff == 32'd0) ? 32'd0 : hhqr_pkg::sat_mag(64'(dnum_n), dneg_ff);
   assign diff   = 33'(signed'(e_val)) - 33'(signed'(mulq));
   assign o_fire = !vld_ff || rsp_tready;
   assign o_last = oph_ff && (or_ff == m_ff - CW'(1)) && (oc_ff == n_ff - CW'(1));
   assign m3 = (rows_ff == 3'd0) ? 3'd1 : ((rows_ff > 3'(MAX_ROWS)) ? 3'(MAX_ROWS) : rows_ff);
   assign n3 = (cols_ff == 3'd0) ? 3'd1 :
               ((cols_ff > m3) ? ((m3 > 3'(MAX_COLS)) ? 3'(MAX_COLS) : m3) :
                ((cols_ff > 3'(MAX_COLS)) ? 3'(MAX_COLS) : cols_ff));

   always_comb begin
      mul_a = w_rd;
      mul_b = e_val;
      case (state_ff)
         ST_NSQ: begin mul_a = r_rd; mul_b = r_rd; end
         ST_DM:  begin mul_a = hhqr_pkg::sat_wide(64'(s_ff)); mul_b = tau_ff; end
         ST_UPM: begin mul_a = d_ff; mul_b = w_rd; end
         default: begin mul_a = w_rd; mul_b = e_val; end
      endcase
   end

   always_comb begin
      state_in = state_ff; rows_in = rows_ff; cols_in = cols_ff;
      m_in = m_ff; n_in = n_ff; j_in = j_ff; k_in = k_ff; c_in = c_ff; ph_in = ph_ff;
      deg_in = deg_ff; prod_in = signed'(64'(signed'(mul_a)) * 64'(signed'(mul_b)));
      acc_in = acc_ff; sx_in = sx_ff; sres_in = sres_ff; sbit_in = sbit_ff; scnt_in = scnt_ff;
      u1_in = u1_ff; tau_in = tau_ff; d_in = d_ff; s_in = s_ff;
      dnum_in = dnum_ff; drem_in = drem_ff; dden_in = dden_ff; dneg_in = dneg_ff;
      dw_in = dw_ff; dcnt_in = dcnt_ff;
      or_in = or_ff; oc_in = oc_ff; oph_in = oph_ff;
      vld_in = vld_ff && !rsp_tready; last_in = last_ff; wm_in = wm_ff;
      orow_in = orow_ff; ocol_in = ocol_ff; oval_in = oval_ff;
      r_we = 1'b0; r_waddr = r_raddr; r_wdata = 32'd0;
      q_we = 1'b0; q_waddr = q_raddr; q_wdata = 32'd0; q_init = 1'b0;
      w_we = 1'b0; w_waddr = k_ff[WIW-1:0]; w_wdata = dres;

      if (csr_valid && csr_ready) begin
         if (csr_index == hhqr_pkg::CSR_ROWS) rows_in = csr_data;
         else if (csr_index == hhqr_pkg::CSR_COLS) cols_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (int'(req_tdata[1:0]) < MAX_ROWS && int'(req_tdata[3:2]) < MAX_COLS) begin
                  r_we = 1'b1;
                  r_waddr = RAW'(int'(req_tdata[1:0]) * MAX_COLS + int'(req_tdata[3:2]));
                  r_wdata = req_tdata[35:4];
               end
               if (req_tlast) begin
                  m_in = m3[CW-1:0]; n_in = n3[CW-1:0];
                  q_init = 1'b1; deg_in = 1'b0;
                  j_in = '0; k_in = '0; acc_in = 64'd0;
                  state_in = ST_NSQ;
               end
            end
         end
         ST_NSQ: state_in = ST_NACC;
         ST_NACC: begin
            acc_in = asum[64] ? 64'hffff_ffff_ffff_ffff : asum[63:0];
            if (k_ff == lm1) begin
               k_in = '0;
               sx_in = asum[64] ? 64'hffff_ffff_ffff_ffff : asum[63:0];
               sres_in = 64'd0; sbit_in = 64'd1 << 62; scnt_in = 5'd0;
               state_in = ST_SQRT;
            end else begin
               k_in = k_ff + CW'(1);
               state_in = ST_NSQ;
            end
         end
         ST_SQRT: begin
            if (sx_ff >= st) begin
               sx_in = sx_ff - st;
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            scnt_in = scnt_ff + 5'd1;
            if (scnt_ff == 5'(hhqr_pkg::SQRT_STEPS - 1)) state_in = ST_PIVOT;
         end
         ST_PIVOT: begin
            if (norm == 32'd0) begin
               deg_in = 1'b1;
               if (j_ff == n_ff - CW'(1)) begin
                  or_in = '0; oc_in = '0; oph_in = hhqr_pkg::MATRIX_Q; state_in = ST_OUT;
               end else begin
                  j_in = j_ff + CW'(1); k_in = '0; acc_in = 64'd0; state_in = ST_NSQ;
               end
            end else begin
               u1_in = u1c;
               dnum_in = {hhqr_pkg::mag32(u1c), {FRAC_BITS{1'b0}}};
               drem_in = 32'd0; dden_in = hhqr_pkg::mag32(bneg);
               dneg_in = u1c[31] ^ bneg[31]; dcnt_in = '0; dw_in = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_WNEXT: begin
            dnum_in = {hhqr_pkg::mag32(r_rd), {FRAC_BITS{1'b0}}};
            drem_in = 32'd0; dden_in = hhqr_pkg::mag32(u1_ff);
            dneg_in = r_rd[31] ^ u1_ff[31]; dcnt_in = '0; dw_in = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dnum_in = dnum_n;
            drem_in = dge ? 32'(drt - {1'b0, dden_ff}) : drt[31:0];
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(NUMW - 1)) begin
               if (!dw_ff) begin
                  tau_in = dres;
                  w_we = 1'b1; w_waddr = '0; w_wdata = ONE;
                  k_in = CW'(1);
                  if (lm1 == '0) begin
                     k_in = '0; c_in = j_ff; ph_in = 1'b0; s_in = '0; state_in = ST_DOTM;
                  end else begin
                     state_in = ST_WNEXT;
                  end
               end else begin
                  w_we = 1'b1;
                  if (k_ff == lm1) begin
                     k_in = '0; c_in = j_ff; ph_in = 1'b0; s_in = '0; state_in = ST_DOTM;
                  end else begin
                     k_in = k_ff + CW'(1); state_in = ST_WNEXT;
                  end
               end
            end
         end
         ST_DOTM: state_in = ST_DOTA;
         ST_DOTA: begin
            s_in = s_ff + 40'(signed'(mulq));
            if (k_ff == lm1) state_in = ST_DM;
            else begin
               k_in = k_ff + CW'(1); state_in = ST_DOTM;
            end
         end
         ST_DM: state_in = ST_DG;
         ST_DG: begin
            d_in = mulq; k_in = '0; state_in = ST_UPM;
         end
         ST_UPM: state_in = ST_UPW;
         ST_UPW: begin
            if (ph_ff) begin
               q_we = 1'b1; q_wdata = hhqr_pkg::sat_wide(64'(diff));
            end else begin
               r_we = 1'b1; r_wdata = hhqr_pkg::sat_wide(64'(diff));
            end
            if (k_ff != lm1) begin
               k_in = k_ff + CW'(1); state_in = ST_UPM;
            end else begin
               k_in = '0; s_in = '0; state_in = ST_DOTM;
               if (!ph_ff) begin
                  if (c_ff == n_ff - CW'(1)) begin
                     ph_in = 1'b1; c_in = '0;
                  end else c_in = c_ff + CW'(1);
               end else if (c_ff != m_ff - CW'(1)) begin
                  c_in = c_ff + CW'(1);
               end else if (j_ff == n_ff - CW'(1)) begin
                  or_in = '0; oc_in = '0; oph_in = hhqr_pkg::MATRIX_Q; state_in = ST_OUT;
               end else begin
                  j_in = j_ff + CW'(1); acc_in = 64'd0; state_in = ST_NSQ;
               end
            end
         end
         ST_OUT: begin
            if (o_fire) begin
               vld_in = 1'b1; wm_in = oph_ff; last_in = o_last;
               orow_in = or_ff[1:0]; ocol_in = oc_ff[1:0];
               oval_in = oph_ff ? r_rd : q_rd;
               if (o_last) state_in = ST_DRAIN;
               else if (oc_ff == (oph_ff ? n_ff : m_ff) - CW'(1)) begin
                  oc_in = '0;
                  if (or_ff == m_ff - CW'(1)) begin
                     or_in = '0; oph_in = hhqr_pkg::MATRIX_R;
                  end else or_in = or_ff + CW'(1);
               end else oc_in = oc_ff + CW'(1);
            end
         end
         ST_DRAIN: if (o_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= 3'd4;
         cols_ff  <= 3'd4;
         deg_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         deg_ff   <= deg_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; n_ff <= n_in; j_ff <= j_in; k_ff <= k_in; c_ff <= c_in; ph_ff <= ph_in;
      prod_ff <= prod_in; acc_ff <= acc_in;
      sx_ff <= sx_in; sres_ff <= sres_in; sbit_ff <= sbit_in; scnt_ff <= scnt_in;
      u1_ff <= u1_in; tau_ff <= tau_in; d_ff <= d_in; s_ff <= s_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dden_ff <= dden_in; dneg_ff <= dneg_in;
      dw_ff <= dw_in; dcnt_ff <= dcnt_in;
      or_ff <= or_in; oc_ff <= oc_in; oph_ff <= oph_in;
      last_ff <= last_in; wm_ff <= wm_in;
      orow_ff <= orow_in; ocol_ff <= ocol_in; oval_ff <= oval_in;
   end

   always_ff @(posedge clock) begin
      if (r_we) r_ff[r_waddr] <= r_wdata;
      if (w_we) w_ff[w_waddr] <= w_wdata;
      if (q_init) begin
         for (int i = 0; i < MAX_ROWS * MAX_ROWS; i++) begin
            q_ff[i] <= ((i / MAX_ROWS) == (i % MAX_ROWS) && (i / MAX_ROWS) < int'(m_in)) ?
                       ONE : 32'd0;
         end
      end else if (q_we) q_ff[q_waddr] <= q_wdata;
   end

   `HHQR_ASSERT(a_idle_no_rsp, req_tready |-> !rsp_tvalid, "response pending while ready")
   `HHQR_ASSERT(a_div_den, state_ff == ST_DIV |-> dden_ff != 32'd0, "divide by zero")
   `HHQR_ASSERT_NEXT(a_start, req_acc && req_tlast, state_ff == ST_NSQ && !deg_ff, "bad start")
   `HHQR_ASSERT(a_last_drain, rsp_tvalid && rsp_tlast |-> state_ff == ST_DRAIN, "tlast early")
endmodule
